// ===== rtl/core/dmrd_pkg.sv =====
package dmrd_pkg;

    localparam int LEVEL_W     = 9;
    localparam int STEP_W      = 8;
    localparam int DT_W        = 16;
    localparam int DUTY_W      = 8;
    localparam int NOW_W       = 32;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    typedef logic signed [LEVEL_W-1:0] t_level;

    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOFT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIMP   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOCKED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DEADTIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL   = 3'd4;

    localparam t_level LEVEL_MIN = -9'sd255;

    // per-side deadtime bookkeeping update
    typedef struct packed {
        logic hold;
        logic load;
    } t_hold_upd;

    // per-side driver outputs
    typedef struct packed {
        logic              dir;
        logic              enable;
        logic [DUTY_W-1:0] duty;
    } t_side_drv;

    // -256 is folded to -255 so levels stay symmetric
    function automatic t_level sat_target(input logic [LEVEL_W-1:0] raw);
        t_level v;
        v = $signed(raw);
        if (raw == {1'b1, {(LEVEL_W-1){1'b0}}}) begin
            v = LEVEL_MIN;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/dmrd_hold.sv =====
module dmrd_hold #(
    parameter int TIME_BITS = 32
) (
    input  dmrd_pkg::t_level              i_cur,
    input  dmrd_pkg::t_level              i_tgt,
    input  logic [TIME_BITS-1:0]          i_now,
    input  logic [dmrd_pkg::DT_W-1:0]     i_deadtime,
    input  logic                          i_hold,
    input  logic [TIME_BITS-1:0]          i_deadline,
    output dmrd_pkg::t_level              o_tgt,
    output logic [TIME_BITS-1:0]          o_deadline,
    output dmrd_pkg::t_hold_upd           o_upd
);
    import dmrd_pkg::*;

    logic                 w_rev;
    logic                 w_start;
    logic                 w_hold_any;
    logic                 w_expired;
    logic [TIME_BITS-1:0] w_dl;

    assign w_rev      = ((i_cur > 0) && (i_tgt < 0)) || ((i_cur < 0) && (i_tgt > 0));
    assign w_start    = w_rev && !i_hold;
    // deadline wraps at the time width
    assign w_dl       = w_start ? (i_now + TIME_BITS'(i_deadtime)) : i_deadline;
    assign w_hold_any = i_hold || w_start;
    assign w_expired  = !(i_now < w_dl);

    assign o_tgt      = (w_hold_any && !w_expired) ? t_level'(0) : i_tgt;
    assign o_deadline = w_dl;
    assign o_upd.load = w_start;
    assign o_upd.hold = w_hold_any && !w_expired;

endmodule

// ===== rtl/core/dmrd_slew.sv =====
module dmrd_slew (
    input  dmrd_pkg::t_level            i_cur,
    input  dmrd_pkg::t_level            i_tgt,
    input  logic [dmrd_pkg::STEP_W-1:0] i_step,
    output dmrd_pkg::t_level            o_level,
    output dmrd_pkg::t_side_drv         o_drv
);
    import dmrd_pkg::*;

    localparam int EXT_W = LEVEL_W + 2;

    logic signed [EXT_W-1:0] w_cur_x;
    logic signed [EXT_W-1:0] w_tgt_x;
    logic signed [EXT_W-1:0] w_step_x;
    logic signed [EXT_W-1:0] w_up;
    logic signed [EXT_W-1:0] w_dn;
    t_level                  w_neg;

    assign w_cur_x  = EXT_W'(i_cur);
    assign w_tgt_x  = EXT_W'(i_tgt);
    assign w_step_x = $signed(EXT_W'(i_step));
    assign w_up     = w_cur_x + w_step_x;
    assign w_dn     = w_cur_x - w_step_x;

    always_comb begin
        if (w_cur_x < w_tgt_x) begin
            o_level = (w_up > w_tgt_x) ? i_tgt : w_up[LEVEL_W-1:0];
        end else if (w_cur_x > w_tgt_x) begin
            o_level = (w_dn < w_tgt_x) ? i_tgt : w_dn[LEVEL_W-1:0];
        end else begin
            o_level = i_cur;
        end
    end

    assign w_neg        = -o_level;
    assign o_drv.dir    = (o_level > 0);
    assign o_drv.enable = (o_level != 0);
    assign o_drv.duty   = (o_level < 0) ? w_neg[DUTY_W-1:0] : o_level[DUTY_W-1:0];

endmodule

// ===== rtl/core/dual_motor_ramp_deadtime_core.sv =====
// A tick's result passes the input register, then the result register, before it is valid.
// Throughput: one tick per cycle unless the output stalls; the level and hold state
// update in the same cycle a tick leaves the input register, so the next tick sees it.
// Reset (synchronous, active low): levels, holds and deadlines zero, registers at
// their defaults, both pipeline registers empty.
module dual_motor_ramp_deadtime_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [dmrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dmrd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // now_ms[31:0], target_left[40:32], target_right[49:41], system_fault[50],
    // drive_mode[52:51], emergency[53], zero pad[55:54]
    input  logic [dmrd_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // left_level[8:0], right_level[17:9], left_dir[18], left_enable[19],
    // left_duty[27:20], right_dir[28], right_enable[29], right_duty[37:30],
    // safe_stop[38], zero pad[39]
    output logic [dmrd_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import dmrd_pkg::*;

    // configuration
    logic [DT_W-1:0]   r_deadtime;
    logic [STEP_W-1:0] r_idle_step;
    logic [STEP_W-1:0] r_soft_step;
    logic [STEP_W-1:0] r_limp_step;
    logic [STEP_W-1:0] r_normal_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadtime    <= DT_W'(200);
            r_idle_step   <= STEP_W'(2);
            r_soft_step   <= STEP_W'(2);
            r_limp_step   <= STEP_W'(4);
            r_normal_step <= STEP_W'(5);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_DEADTIME: r_deadtime    <= i_cfg_wdata;
                REG_IDLE:     r_idle_step   <= i_cfg_wdata[STEP_W-1:0];
                REG_SOFT:     r_soft_step   <= i_cfg_wdata[STEP_W-1:0];
                REG_LIMP:     r_limp_step   <= i_cfg_wdata[STEP_W-1:0];
                REG_NORMAL:   r_normal_step <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    logic               r_s1_valid;
    logic [NOW_W-1:0]   r_in_now;
    logic [LEVEL_W-1:0] r_in_tl;
    logic [LEVEL_W-1:0] r_in_tr;
    logic               r_in_fault;
    logic [MODE_W-1:0]  r_in_mode;
    logic               r_in_emerg;

    logic r_out_valid;
    logic w_adv;
    logic w_fire;
    logic w_in_xfer;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_fire     = r_s1_valid && w_adv;
    assign o_s_tready = !r_s1_valid || w_adv;
    assign w_in_xfer  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_now   <= i_s_tdata[31:0];
            r_in_tl    <= i_s_tdata[40:32];
            r_in_tr    <= i_s_tdata[49:41];
            r_in_fault <= i_s_tdata[50];
            r_in_mode  <= i_s_tdata[52:51];
            r_in_emerg <= i_s_tdata[53];
        end
    end

    // drive state
    t_level               r_left_level;
    t_level               r_right_level;
    logic                 r_left_hold;
    logic                 r_right_hold;
    logic [TIME_BITS-1:0] r_left_deadline;
    logic [TIME_BITS-1:0] r_right_deadline;

    logic [TIME_BITS-1:0] w_now;
    t_level               w_tl;
    t_level               w_tr;
    t_level               w_hl_tgt;
    t_level               w_hr_tgt;
    logic [TIME_BITS-1:0] w_hl_dl;
    logic [TIME_BITS-1:0] w_hr_dl;
    t_hold_upd            w_hl_upd;
    t_hold_upd            w_hr_upd;
    logic [STEP_W-1:0]    w_step;
    t_level               w_l_level;
    t_level               w_r_level;
    t_side_drv            w_l_drv;
    t_side_drv            w_r_drv;
    logic                 w_kill;

    assign w_now  = TIME_BITS'(r_in_now);
    assign w_tl   = r_in_emerg ? t_level'(0) : sat_target(r_in_tl);
    assign w_tr   = r_in_emerg ? t_level'(0) : sat_target(r_in_tr);
    assign w_kill = r_in_fault || (r_in_mode == MODE_LOCKED);

    dmrd_hold #(.TIME_BITS(TIME_BITS)) u_hold_left (
        .i_cur      (r_left_level),
        .i_tgt      (w_tl),
        .i_now      (w_now),
        .i_deadtime (r_deadtime),
        .i_hold     (r_left_hold),
        .i_deadline (r_left_deadline),
        .o_tgt      (w_hl_tgt),
        .o_deadline (w_hl_dl),
        .o_upd      (w_hl_upd)
    );

    dmrd_hold #(.TIME_BITS(TIME_BITS)) u_hold_right (
        .i_cur      (r_right_level),
        .i_tgt      (w_tr),
        .i_now      (w_now),
        .i_deadtime (r_deadtime),
        .i_hold     (r_right_hold),
        .i_deadline (r_right_deadline),
        .o_tgt      (w_hr_tgt),
        .o_deadline (w_hr_dl),
        .o_upd      (w_hr_upd)
    );

    always_comb begin
        if ((w_hl_tgt == 0) && (w_hr_tgt == 0)) begin
            w_step = r_idle_step;
        end else begin
            case (r_in_mode)
                MODE_SOFT: w_step = r_soft_step;
                MODE_LIMP: w_step = r_limp_step;
                default:   w_step = r_normal_step;
            endcase
        end
    end

    dmrd_slew u_slew_left (
        .i_cur   (r_left_level),
        .i_tgt   (w_hl_tgt),
        .i_step  (w_step),
        .o_level (w_l_level),
        .o_drv   (w_l_drv)
    );

    dmrd_slew u_slew_right (
        .i_cur   (r_right_level),
        .i_tgt   (w_hr_tgt),
        .i_step  (w_step),
        .o_level (w_r_level),
        .o_drv   (w_r_drv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_level     <= '0;
            r_right_level    <= '0;
            r_left_hold      <= 1'b0;
            r_right_hold     <= 1'b0;
            r_left_deadline  <= '0;
            r_right_deadline <= '0;
        end else if (w_fire) begin
            if (w_kill) begin
                r_left_level     <= '0;
                r_right_level    <= '0;
                r_left_hold      <= 1'b0;
                r_right_hold     <= 1'b0;
                r_left_deadline  <= '0;
                r_right_deadline <= '0;
            end else begin
                r_left_level  <= w_l_level;
                r_right_level <= w_r_level;
                r_left_hold   <= w_hl_upd.hold;
                r_right_hold  <= w_hr_upd.hold;
                if (w_hl_upd.load) begin
                    r_left_deadline <= w_hl_dl;
                end
                if (w_hr_upd.load) begin
                    r_right_deadline <= w_hr_dl;
                end
            end
        end
    end

    // result register
    logic [OUT_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            if (w_kill) begin
                r_out_data <= {1'b0, 1'b1, {(OUT_TDATA_W-2){1'b0}}};
            end else begin
                r_out_data <= {1'b0, 1'b0,
                               w_r_drv.duty, w_r_drv.enable, w_r_drv.dir,
                               w_l_drv.duty, w_l_drv.enable, w_l_drv.dir,
                               w_r_level, w_l_level};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // assertions
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_adv |=> r_s1_valid && $stable(r_in_now))
        else $error("input register dropped a stalled tick");

    a_kill_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_kill |=> (r_left_level == 0) && (r_right_level == 0)
                             && !r_left_hold && !r_right_hold)
        else $error("fault path left drive state active");

    a_fire_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_m_tvalid)
        else $error("processed tick produced no result");

    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !w_kill && w_hl_upd.hold |=> $past(w_hl_tgt) == 0)
        else $error("left target passed during deadtime hold");

endmodule
